/* rtl/assert_macros.svh */
// Assertion macros for the RTL, used by integer_to_radix_string.sv.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold at every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Expression must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg)

`endif

`endif

/* rtl/itr_pkg.sv */
// Types and constants for the integer to radix text converter.
// No dependencies.
package itr_pkg;

  localparam int RADIX_W    = 6;
  localparam int CFG_W      = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int SYM_W      = 8;
  localparam int ALPHA_REGS = 4;
  localparam int ALPHA_W    = ALPHA_REGS * CFG_W;
  localparam int SYM_IDX_W  = 5;

  localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
  localparam logic [SYM_W-1:0]   MINUS_CODE  = 8'h2D;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_RADIX   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_3 = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CONV = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

endpackage

/* rtl/integer_to_radix_string.sv */
// Top level of the integer to radix text converter.
// Depends on itr_pkg and assert_macros.svh.
//
// Input channel (in_valid / in_stall / in_value): one signed integer per
//   transfer, taken at a rising edge with valid high and stall low.
// Result channel (out_valid / out_stall / out_char_code / out_last): the text,
//   one character per transfer, most significant digit first, with a leading
//   minus sign for negative values; out_last marks the final character.
// Configuration: cfg_we with cfg_index 0 writes the radix (clamped to
//   2..MAX_RADIX when used), indexes 1 to 4 the 32-symbol alphabet. Write it
//   only while the block is idle.
// Timing: the magnitude is shifted in one bit per cycle through a radix-r
//   doubler; then one character per cycle is loaded into the output
//   register, as long as the result side does not stall it.
//   in_stall is high from the transfer until the last character is loaded,
//   which may still wait in the output register while the next value is
//   taken. A stall on the result side holds that register and pauses emission.
// Reset: synchronous, active low; radix returns to 10, alphabet to zero, and
//   the block goes idle with no result pending.
`include "assert_macros.svh"

module integer_to_radix_string
  import itr_pkg::*;
#(
  parameter int MAX_RADIX   = 32,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [VALUE_WIDTH-1:0] in_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [SYM_W-1:0]              out_char_code,
  output logic                          out_last,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_W-1:0]              cfg_data
);

  // Digit width covers values 0..MAX_RADIX-1; radix 2 needs VALUE_WIDTH digits
  localparam int DIG_W  = $clog2(MAX_RADIX);
  localparam int RAD_W  = DIG_W + 1;
  localparam int NDIG   = VALUE_WIDTH;
  localparam int NDW    = $clog2(NDIG + 1);
  localparam int IDXW   = $clog2(NDIG);
  localparam int BCW    = $clog2(VALUE_WIDTH);

  // Configuration registers
  logic [RADIX_W-1:0]  radix_r;
  logic [ALPHA_W-1:0]  alpha_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RADIX_RESET;
      alpha_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RADIX:   radix_r <= cfg_data[RADIX_W-1:0];
        CFG_ALPHA_0: alpha_r[0*CFG_W +: CFG_W] <= cfg_data;
        CFG_ALPHA_1: alpha_r[1*CFG_W +: CFG_W] <= cfg_data;
        CFG_ALPHA_2: alpha_r[2*CFG_W +: CFG_W] <= cfg_data;
        CFG_ALPHA_3: alpha_r[3*CFG_W +: CFG_W] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp the radix into 2..MAX_RADIX
  logic [RAD_W-1:0] rad_eff;

  always_comb begin
    if (radix_r < RADIX_W'(2)) begin
      rad_eff = RAD_W'(2);
    end else if (radix_r > RADIX_W'(MAX_RADIX)) begin
      rad_eff = RAD_W'(MAX_RADIX);
    end else begin
      rad_eff = RAD_W'(radix_r);
    end
  end

  // Sequencer and datapath registers
  state_t                 state_r, state_nxt;
  logic [VALUE_WIDTH-1:0] mag_r, mag_nxt;
  logic [BCW-1:0]         bit_cnt_r, bit_cnt_nxt;
  logic [NDW-1:0]         ndig_r, ndig_nxt;
  logic                   sign_pend_r, sign_pend_nxt;
  logic [DIG_W-1:0]       dig_r   [NDIG];
  logic [DIG_W-1:0]       dig_nxt [NDIG];
  logic                   out_valid_r, out_valid_nxt;
  logic [SYM_W-1:0]       out_char_r, out_char_nxt;
  logic                   out_last_r, out_last_nxt;

  // Radix-r doubler: every digit becomes 2*d + carry-in, reduced by the radix
  // when it overflows. Carry runs as a generate/propagate chain.
  logic [NDIG:0]          carry;
  logic [DIG_W-1:0]       dig_step [NDIG];

  always_comb begin
    logic             gen;
    logic             prop;
    logic [RAD_W-1:0] sum;
    carry[0] = mag_r[VALUE_WIDTH-1];
    for (int i = 0; i < NDIG; i++) begin
      gen          = ({dig_r[i], 1'b0} >= rad_eff);
      prop         = ({dig_r[i], 1'b1} == rad_eff);
      carry[i+1]   = gen | (prop & carry[i]);
      sum          = {dig_r[i], carry[i]};
      sum          = carry[i+1] ? (sum - rad_eff) : sum;
      dig_step[i]  = sum[DIG_W-1:0];
    end
  end

  // Digit count grows when a carry reaches the first empty position
  logic [NDW-1:0] ndig_grow;
  assign ndig_grow = carry[ndig_r] ? (ndig_r + NDW'(1)) : ndig_r;

  // Symbol of the current digit
  logic [IDXW-1:0]      emit_idx;
  logic [SYM_IDX_W-1:0] sym_idx;
  logic [SYM_W-1:0]     sym_code;

  assign emit_idx = IDXW'(ndig_r - NDW'(1));
  assign sym_idx  = SYM_IDX_W'(dig_r[emit_idx]);
  assign sym_code = alpha_r[sym_idx*SYM_W +: SYM_W];

  logic in_xfer;
  logic out_free;

  assign in_stall = (state_r != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    mag_nxt       = mag_r;
    bit_cnt_nxt   = bit_cnt_r;
    ndig_nxt      = ndig_r;
    sign_pend_nxt = sign_pend_r;
    dig_nxt       = dig_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          // Take the unsigned magnitude so the most negative value is exact
          sign_pend_nxt = in_value[VALUE_WIDTH-1];
          mag_nxt       = in_value[VALUE_WIDTH-1] ? (~$unsigned(in_value) +
                          VALUE_WIDTH'(1)) : $unsigned(in_value);
          bit_cnt_nxt   = BCW'(VALUE_WIDTH - 1);
          ndig_nxt      = '0;
          for (int i = 0; i < NDIG; i++) begin
            dig_nxt[i] = '0;
          end
          state_nxt     = ST_CONV;
        end
      end
      ST_CONV: begin
        dig_nxt  = dig_step;
        mag_nxt  = {mag_r[VALUE_WIDTH-2:0], 1'b0};
        ndig_nxt = ndig_grow;
        if (bit_cnt_r == '0) begin
          // Zero still gives one digit
          if (ndig_grow == '0) begin
            ndig_nxt = NDW'(1);
          end
          state_nxt = ST_EMIT;
        end else begin
          bit_cnt_nxt = bit_cnt_r - BCW'(1);
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (sign_pend_r) begin
            out_char_nxt  = MINUS_CODE;
            out_last_nxt  = 1'b0;
            sign_pend_nxt = 1'b0;
          end else begin
            out_char_nxt = sym_code;
            out_last_nxt = (ndig_r == NDW'(1));
            ndig_nxt     = ndig_r - NDW'(1);
            if (ndig_r == NDW'(1)) begin
              state_nxt = ST_IDLE;
            end
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      sign_pend_r <= 1'b0;
      ndig_r      <= '0;
      bit_cnt_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      sign_pend_r <= sign_pend_nxt;
      ndig_r      <= ndig_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
    end
  end

  // Payload: no reset needed
  always_ff @(posedge clk) begin
    mag_r      <= mag_nxt;
    dig_r      <= dig_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_char_code = out_char_r;
  assign out_last      = out_last_r;

  // Checks on the sequencer
  `ASSERT_NEVER(a_ndig_range, clk, rst_n, ndig_r > NDW'(NDIG), "digit count overflow")
  `ASSERT_PROP(a_emit_has_digit, clk, rst_n, (state_r == ST_EMIT) |-> (ndig_r != '0), "no digit")
  `ASSERT_PROP(a_conv_length, clk, rst_n, in_xfer |-> ##(NDIG+1) (state_r == ST_EMIT), "length")

endmodule

/* test/integer_to_radix_string_checker.sv */
`timescale 1ns / 100ps
// Scoreboard for integer_to_radix_string: snoops the configuration port and both
// channels, predicts the text of every value taken and compares it per character.
// Depends on itr_pkg.
module integer_to_radix_string_checker
  import itr_pkg::*;
#(
  parameter int MAX_RADIX   = 32,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic signed [VALUE_WIDTH-1:0] in_value,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [SYM_W-1:0]              out_char_code,
  input  logic                          out_last,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_W-1:0]              cfg_data,
  output int                            mismatches,
  output int                            chars_outstanding
);

  typedef struct packed {
    logic [SYM_W-1:0] code;
    logic             last;
  } text_char_t;

  text_char_t         expected_text[$];
  logic [RADIX_W-1:0] radix_q;
  logic [ALPHA_W-1:0] symbols_q;

  // Append the characters of one value, most significant digit first.
  function automatic void queue_text_of(input logic [VALUE_WIDTH-1:0] v);
    logic [VALUE_WIDTH-1:0] mag;
    logic [VALUE_WIDTH-1:0] base;
    logic [SYM_IDX_W-1:0]   digits[VALUE_WIDTH];
    int                     r;
    int                     n;
    r = radix_q;
    if (r < 2) r = 2;
    if (r > MAX_RADIX) r = MAX_RADIX;
    base = VALUE_WIDTH'(r);
    // unsigned magnitude, so the most negative value stays exact
    mag = v[VALUE_WIDTH-1] ? ~v + 1'b1 : v;
    n = 0;
    do begin
      digits[n] = SYM_IDX_W'(mag % base);
      mag = mag / base;
      n++;
    end while (mag != 0 && n < VALUE_WIDTH);
    if (v[VALUE_WIDTH-1]) expected_text.push_back('{MINUS_CODE, 1'b0});
    for (int k = n - 1; k >= 0; k--)
      expected_text.push_back('{symbols_q[digits[k]*SYM_W +: SYM_W], k == 0});
  endfunction

  always @(posedge clk) begin
    text_char_t want;
    if (!rst_n) begin
      radix_q   <= RADIX_RESET;
      symbols_q <= '0;
      expected_text.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_text.size() == 0) begin
          mismatches++;
          $display("%0t: expected nothing, got char_code %02h last %0b",
                   $time, out_char_code, out_last);
        end else begin
          want = expected_text.pop_front();
          if (out_char_code !== want.code) begin
            mismatches++;
            $display("%0t: char_code expected %02h, got %02h",
                     $time, want.code, out_char_code);
          end
          if (out_last !== want.last) begin
            mismatches++;
            $display("%0t: last expected %0b, got %0b", $time, want.last, out_last);
          end
        end
      end
      if (in_valid && !in_stall) queue_text_of(in_value);
      if (cfg_we) begin
        case (cfg_index)
          CFG_RADIX:   radix_q <= cfg_data[RADIX_W-1:0];
          CFG_ALPHA_0: symbols_q[0*CFG_W +: CFG_W] <= cfg_data;
          CFG_ALPHA_1: symbols_q[1*CFG_W +: CFG_W] <= cfg_data;
          CFG_ALPHA_2: symbols_q[2*CFG_W +: CFG_W] <= cfg_data;
          CFG_ALPHA_3: symbols_q[3*CFG_W +: CFG_W] <= cfg_data;
          default: ;
        endcase
      end
    end
    chars_outstanding <= expected_text.size();
  end

endmodule

/* test/integer_to_radix_string_test.sv */
`timescale 1ns / 100ps
// Top of the integer_to_radix_string testbench: clock, reset, configuration and
// stimulus, with the scoreboard in integer_to_radix_string_checker beside the block.
// Depends on itr_pkg, the block and the checker.
module integer_to_radix_string_test;
  import itr_pkg::*;

  localparam int MAX_RADIX       = 32;
  localparam int VALUE_WIDTH     = 32;
  localparam int HOLD_CYCLES     = 300;
  localparam int RANDOM_PHASES   = 6;
  localparam int ITEMS_PER_PHASE = 34;
  localparam int SETTLE_CYCLES   = 80;

  // "0123456789ABCDEFGHIJKLMNOPQRSTUV", digit value 0 in the low byte
  localparam logic [CFG_W-1:0] DIGITS_0 = 64'h3736353433323130;
  localparam logic [CFG_W-1:0] DIGITS_1 = 64'h4645444342413938;
  localparam logic [CFG_W-1:0] DIGITS_2 = 64'h4E4D4C4B4A494847;
  localparam logic [CFG_W-1:0] DIGITS_3 = 64'h565554535251504F;

  logic                          clk       = 1'b0;
  logic                          rst_n     = 1'b0;
  logic                          in_valid  = 1'b0;
  logic                          in_stall;
  logic signed [VALUE_WIDTH-1:0] in_value  = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [SYM_W-1:0]              out_char_code;
  logic                          out_last;
  logic                          cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]          cfg_index = CFG_RADIX;
  logic [CFG_W-1:0]              cfg_data  = '0;

  // calm: no idling on either side; hold_asked: count of long receiver hold-offs
  logic calm         = 1'b0;
  int   hold_asked   = 0;
  int   active_radix = RADIX_RESET;
  int   mismatches;
  int   chars_outstanding;

  integer_to_radix_string #(
    .MAX_RADIX  (MAX_RADIX),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_char_code(out_char_code),
    .out_last     (out_last),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  integer_to_radix_string_checker #(
    .MAX_RADIX  (MAX_RADIX),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_char_code    (out_char_code),
    .out_last         (out_last),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .mismatches       (mismatches),
    .chars_outstanding(chars_outstanding)
  );

  always #5 clk = ~clk;

  // Gap length in cycles: mostly short, now and then long.
  function automatic int idle_length();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  // Draw a value: small numbers, extremes, powers of the radix and plain noise.
  function automatic logic [VALUE_WIDTH-1:0] pick_value();
    longint p;
    int     r;
    p = 1;
    r = active_radix;
    if (r < 2) r = 2;
    if (r > MAX_RADIX) r = MAX_RADIX;
    case ($urandom_range(0, 5))
      0: begin
        p = $urandom_range(0, 40);
        return $urandom_range(0, 1) ? VALUE_WIDTH'(-p) : VALUE_WIDTH'(p);
      end
      1: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'hFFFF_FFFF;
          default: return 32'h0000_0000;
        endcase
      end
      2: begin
        // around a power of the radix, where the digit count steps up
        repeat ($urandom_range(1, 8)) p = p * r;
        p = p + $urandom_range(0, 2) - 1;
        return $urandom_range(0, 1) ? VALUE_WIDTH'(-p) : VALUE_WIDTH'(p);
      end
      default: return $urandom();
    endcase
  endfunction

  // Offer one value and hold it until the transfer; then maybe drop valid for a gap.
  task automatic offer(input logic [VALUE_WIDTH-1:0] v);
    in_valid <= 1'b1;
    in_value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (!calm && $urandom_range(0, 2) == 0) begin
      in_valid <= 1'b0;
      repeat (idle_length()) @(posedge clk);
    end
  endtask

  // Stop offering and wait until every predicted character has been taken.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (chars_outstanding != 0) @(posedge clk);
  endtask

  // One register write; the caller drops cfg_we after the last of a batch.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    if (idx == CFG_RADIX) active_radix = data[RADIX_W-1:0];
    @(posedge clk);
  endtask

  // Radix write with junk above the field, which the block must ignore.
  task automatic apply_radix(input int r);
    cfg_write(CFG_RADIX, {(CFG_W-RADIX_W)'({$urandom(), $urandom()}), RADIX_W'(r)});
    cfg_we <= 1'b0;
  endtask

  task automatic apply_setting(input int r, input logic [CFG_W-1:0] a0,
                               input logic [CFG_W-1:0] a1, input logic [CFG_W-1:0] a2,
                               input logic [CFG_W-1:0] a3);
    cfg_write(CFG_ALPHA_0, a0);
    cfg_write(CFG_ALPHA_1, a1);
    cfg_write(CFG_ALPHA_2, a2);
    cfg_write(CFG_ALPHA_3, a3);
    apply_radix(r);
  endtask

  // Receiver: random stalls, plus a long hold-off each time one is asked for.
  // The hold-off is counted here so the sender keeps offering meanwhile.
  initial begin : receiver
    int stall_left;
    int hold_served;
    stall_left  = 0;
    hold_served = 0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (hold_served != hold_asked) begin
        hold_served++;
        stall_left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        stall_left = idle_length() - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    int r;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset setting: radix ten with an all-zero alphabet.
    offer(32'd0);
    offer(32'hFFFF_FFFF);

    // Decimal with readable symbols: zero, both extremes, minus one, one.
    drain();
    apply_setting(10, DIGITS_0, DIGITS_1, DIGITS_2, DIGITS_3);
    offer(32'd0);
    offer(32'h7FFF_FFFF);
    offer(32'h8000_0000);
    offer(32'hFFFF_FFFF);
    offer(32'd1);

    // Binary: the most negative value gives the longest text.
    drain();
    apply_radix(2);
    offer(32'h8000_0000);
    offer(32'h7FFF_FFFF);
    offer(32'd0);
    offer(32'd1);

    // Largest radix: every symbol of the alphabet is reachable.
    drain();
    apply_radix(MAX_RADIX);
    offer(32'h8000_0000);
    offer(32'd31);
    offer(32'd32);
    offer(32'hFFFF_FFFF);

    // Radix zero and one clamp up to two; above the maximum clamps down.
    drain();
    apply_radix(0);
    offer(32'd5);
    drain();
    apply_radix(1);
    offer(-32'sd6);
    drain();
    apply_radix(63);
    offer(32'd12345);
    drain();
    apply_radix(MAX_RADIX + 1);
    offer(-32'sd1000);

    // Writes to the spare indexes must leave the setting alone.
    drain();
    for (int k = 1; k <= 3; k++)
      cfg_write(CFG_ALPHA_3 + CFG_IDX_W'(k), {$urandom(), $urandom()});
    apply_radix(16);
    offer(32'hDEAD_BEEF);

    // Random phases: fresh radix and random alphabet each time. One phase runs
    // without idling, one carries the long receiver hold-off.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      drain();
      if (ph == 0) r = 2;
      else if (ph == 1) r = MAX_RADIX;
      else if ($urandom_range(0, 3) == 0) r = $urandom_range(0, 63);
      else r = $urandom_range(2, MAX_RADIX);
      apply_setting(r, {$urandom(), $urandom()}, {$urandom(), $urandom()},
                    {$urandom(), $urandom()}, {$urandom(), $urandom()});
      calm <= (ph == 2);
      if (ph == 4) hold_asked <= hold_asked + 1;
      repeat (ITEMS_PER_PHASE) offer(pick_value());
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("integer_to_radix_string: match");
    else
      $display("integer_to_radix_string: mismatch");
    $finish;
  end

  // Guard against a hung handshake.
  initial begin : watchdog
    #20_000_000;
    $display("integer_to_radix_string: mismatch");
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/itr_pkg.sv
rtl/integer_to_radix_string.sv
test/integer_to_radix_string_checker.sv
test/integer_to_radix_string_test.sv
